@@ hw/rtl/servo_command_frame_builder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Servo command frame builder assertion macros
// Shared concurrent assertion shorthands for the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_COMMAND_FRAME_BUILDER_UNIT_DEFINES_SVH
`define SERVO_COMMAND_FRAME_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame builder check failed");

// Next-cycle implication, checked outside reset.
`define SCFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame builder check failed");

`endif

@@ hw/rtl/scfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo command frame builder package
// Command codes, frame constants and the queued command entry type.
// ----------------------------------------------------------------------------
package scfb_pkg;

   typedef enum logic {
      OP_MOVE = 1'b0,
      OP_READ = 1'b1
   } op_type;

   localparam logic [7:0] HDR_BYTE     = 8'hFF;
   localparam logic [7:0] LEN_MOVE     = 8'd7;
   localparam logic [7:0] INSTR_WRITE  = 8'd3;
   localparam logic [7:0] ADDR_POSTIME = 8'd42;
   localparam logic [7:0] LEN_READ     = 8'd4;
   localparam logic [7:0] INSTR_READ   = 8'd2;
   localparam logic [7:0] ADDR_POS     = 8'd56;
   localparam logic [7:0] READ_COUNT   = 8'd2;

   // Byte positions within a frame
   localparam logic [3:0] BYTE_HDR0  = 4'd0;
   localparam logic [3:0] BYTE_HDR1  = 4'd1;
   localparam logic [3:0] BYTE_ID    = 4'd2;
   localparam logic [3:0] BYTE_LEN   = 4'd3;
   localparam logic [3:0] BYTE_INSTR = 4'd4;
   localparam logic [3:0] BYTE_ADDR  = 4'd5;
   localparam logic [3:0] BYTE_D0    = 4'd6;
   localparam logic [3:0] BYTE_D1    = 4'd7;
   localparam logic [3:0] BYTE_D2    = 4'd8;
   localparam logic [3:0] BYTE_D3    = 4'd9;
   localparam logic [3:0] MOVE_LAST  = 4'd10;
   localparam logic [3:0] READ_LAST  = 4'd7;

   typedef struct packed {
      op_type      op;
      logic [7:0]  servo_id;
      logic [15:0] target_position;
      logic [15:0] move_time;
      logic [7:0]  checksum;
   } cmd_entry_type;

endpackage

@@ hw/rtl/scfb_front.sv @@
// ----------------------------------------------------------------------------
// Frame builder front end
// Classifies an incoming command and precomputes its frame checksum.
// ----------------------------------------------------------------------------
module scfb_front
   import scfb_pkg::*;
(
   input  logic          req_valid,
   input  logic          req_operation,
   input  logic [7:0]    req_servo_id,
   input  logic [15:0]   req_target_position,
   input  logic [15:0]   req_move_time,
   input  logic          queue_full,
   output logic          req_ready,
   output logic          push,
   output cmd_entry_type push_entry
);

   logic [7:0] sum;

   always_comb begin
      if (op_type'(req_operation) == OP_READ) begin
         sum = req_servo_id + LEN_READ + INSTR_READ + ADDR_POS + READ_COUNT;
      end else begin
         sum = req_servo_id + LEN_MOVE + INSTR_WRITE + ADDR_POSTIME
             + req_target_position[15:8] + req_target_position[7:0]
             + req_move_time[15:8] + req_move_time[7:0];
      end
   end

   assign req_ready                  = ~queue_full;
   assign push                       = req_valid & ~queue_full;
   assign push_entry.op              = op_type'(req_operation);
   assign push_entry.servo_id        = req_servo_id;
   assign push_entry.target_position = req_target_position;
   assign push_entry.move_time       = req_move_time;
   assign push_entry.checksum        = ~sum;

endmodule

@@ hw/rtl/scfb_queue.sv @@
// ----------------------------------------------------------------------------
// Frame builder command queue
// Short register FIFO between the front end and the byte serializer.
// ----------------------------------------------------------------------------
module scfb_queue
   import scfb_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          head_valid,
   output cmd_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/scfb_back.sv @@
// ----------------------------------------------------------------------------
// Frame builder back end
// Walks the head command byte by byte into a registered output word.
// ----------------------------------------------------------------------------
`include "servo_command_frame_builder_unit_defines.svh"

module scfb_back
   import scfb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cmd_entry_type head_entry,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_frame_byte,
   output logic          rsp_last_byte
);

   logic [3:0] index_ff, index_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       is_read;
   logic       at_last;
   logic       load;
   logic [7:0] sel_byte;

   assign is_read = (head_entry.op == OP_READ);
   assign at_last = (index_ff == (is_read ? READ_LAST : MOVE_LAST));
   // refill the output word when it is empty or being taken
   assign load    = head_valid & (~rsp_valid_ff | rsp_ready);
   assign pop     = load & at_last;

   always_comb begin
      case (index_ff)
         BYTE_HDR0, BYTE_HDR1: sel_byte = HDR_BYTE;
         BYTE_ID:    sel_byte = head_entry.servo_id;
         BYTE_LEN:   sel_byte = is_read ? LEN_READ : LEN_MOVE;
         BYTE_INSTR: sel_byte = is_read ? INSTR_READ : INSTR_WRITE;
         BYTE_ADDR:  sel_byte = is_read ? ADDR_POS : ADDR_POSTIME;
         BYTE_D0:    sel_byte = is_read ? READ_COUNT : head_entry.target_position[15:8];
         BYTE_D1:    sel_byte = is_read ? head_entry.checksum
                                        : head_entry.target_position[7:0];
         BYTE_D2:    sel_byte = head_entry.move_time[15:8];
         BYTE_D3:    sel_byte = head_entry.move_time[7:0];
         default:    sel_byte = head_entry.checksum;
      endcase
   end

   always_comb begin
      index_in     = index_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (load) begin
         index_in     = at_last ? '0 : index_ff + 1'b1;
         rsp_byte_in  = sel_byte;
         rsp_last_in  = at_last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_last_byte  = rsp_last_ff;

   `SCFB_ASSERT_NOW(a_mid_frame_has_head, clock, reset, index_ff != '0, head_valid)
   `SCFB_ASSERT_NOW(a_index_in_range, clock, reset, 1'b1, index_ff <= MOVE_LAST)
   `SCFB_ASSERT_NOW(a_read_index_in_range, clock, reset, head_valid && is_read, index_ff <= READ_LAST)
   `SCFB_ASSERT_NEXT(a_pop_marks_last, clock, reset, pop, rsp_valid_ff && rsp_last_ff && index_ff == '0)

endmodule

@@ hw/rtl/servo_command_frame_builder_unit.sv @@
// ----------------------------------------------------------------------------
// Servo command frame builder
// Turns move and position-read commands into serial instruction frames.
// ----------------------------------------------------------------------------
// Each accepted command produces one instruction frame on the rsp_ channel,
// one byte per word, with rsp_last_byte set on the trailing checksum byte.
// A move takes 11 words, a read request 8; the serializer emits at most one
// byte per cycle, stalling while rsp_ready is low. Frames follow each other
// with no gap while the next command is already queued. Commands are classified
// and checksummed on entry and wait in a QUEUE_DEPTH-entry queue, so req_ready
// stays high while a frame is being sent until the queue fills.
module servo_command_frame_builder_unit
   import scfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_servo_id,
   input  logic [15:0] req_target_position,
   input  logic [15:0] req_move_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte
);

   logic          push;
   cmd_entry_type push_entry;
   logic          queue_full;
   logic          head_valid;
   cmd_entry_type head_entry;
   logic          pop;

   scfb_front u_front (
      .req_valid           (req_valid),
      .req_operation       (req_operation),
      .req_servo_id        (req_servo_id),
      .req_target_position (req_target_position),
      .req_move_time       (req_move_time),
      .queue_full          (queue_full),
      .req_ready           (req_ready),
      .push                (push),
      .push_entry          (push_entry)
   );

   scfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   scfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

@@ verif/servo_command_frame_builder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Servo command frame builder testbench
// Sends move and position-read commands and checks every frame byte, and its
// last flag, against frames built independently here, under random back
// pressure on the result channel and random gaps between commands.
// ----------------------------------------------------------------------------
module servo_command_frame_builder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scfb_pkg::*;

   localparam int STUCK_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 115;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_word_type;

   class frame_scoreboard;
      frame_word_type expected_words[$];
      int mismatches;
      int words_checked;
      int moves;
      int reads;

      function new();
         mismatches    = 0;
         words_checked = 0;
         moves         = 0;
         reads         = 0;
      endfunction

      // Build the whole instruction frame for one accepted command.
      function void note_command(op_type op, logic [7:0] id, logic [15:0] pos,
                                 logic [15:0] tim);
         logic [7:0]     frame [11];
         int             n;
         logic [7:0]     sum;
         frame_word_type w;
         frame[0] = HDR_BYTE;
         frame[1] = HDR_BYTE;
         frame[2] = id;
         if (op == OP_MOVE) begin
            frame[3] = LEN_MOVE;
            frame[4] = INSTR_WRITE;
            frame[5] = ADDR_POSTIME;
            frame[6] = pos[15:8];
            frame[7] = pos[7:0];
            frame[8] = tim[15:8];
            frame[9] = tim[7:0];
            n = 11;
            moves++;
         end else begin
            frame[3] = LEN_READ;
            frame[4] = INSTR_READ;
            frame[5] = ADDR_POS;
            frame[6] = READ_COUNT;
            n = 8;
            reads++;
         end
         // checksum covers id through the byte ahead of it, wrapping at 8 bits
         sum = 8'h00;
         for (int k = 2; k < n - 1; k++) sum = sum + frame[k];
         frame[n - 1] = ~sum;
         for (int k = 0; k < n; k++) begin
            w.value = frame[k];
            w.last  = (k == n - 1);
            expected_words.push_back(w);
         end
      endfunction

      function void check_byte(logic [7:0] value, logic last);
         frame_word_type w;
         words_checked++;
         if (expected_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected frame byte %02h (last %0b), none expected",
                     $time, value, last);
            return;
         end
         w = expected_words.pop_front();
         if (value !== w.value) begin
            mismatches++;
            $display("%0t: frame_byte expected %02h actual %02h", $time, w.value, value);
         end
         if (last !== w.last) begin
            mismatches++;
            $display("%0t: last_byte expected %0b actual %0b", $time, w.last, last);
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [7:0]  req_servo_id = 8'h00;
   logic [15:0] req_target_position = 16'h0000;
   logic [15:0] req_move_time = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;

   frame_scoreboard sb;
   bit              calm = 1'b0;
   int              stuck_cycles = 0;

   servo_command_frame_builder_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_servo_id        (req_servo_id),
      .req_target_position (req_target_position),
      .req_move_time       (req_move_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_last_byte       (rsp_last_byte)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check each accepted word, throttle the result side, and watch for a hang.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_byte(rsp_frame_byte, rsp_last_byte);
      end
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles < STUCK_LIMIT) begin
         stuck_cycles <= stuck_cycles + 1;
      end else begin
         $display("%0t: no word moved in %0d cycles", $time, STUCK_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Hold the command until taken; leave valid high so the next one can follow.
   task automatic send_command(op_type op, logic [7:0] id, logic [15:0] pos,
                               logic [15:0] tim);
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_servo_id        <= id;
      req_target_position <= pos;
      req_move_time       <= tim;
      do @(posedge clock); while (!req_ready);
      sb.note_command(op, id, pos, tim);
      if (!calm && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_field16();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      op_type op;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // field extremes and checksum wrap for moves
      send_command(OP_MOVE, 8'h00, 16'h0000, 16'h0000);
      send_command(OP_MOVE, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_command(OP_MOVE, 8'hFE, 16'hFF00, 16'h00FF);
      send_command(OP_MOVE, 8'h01, 16'h00FF, 16'hFF00);
      send_command(OP_MOVE, 8'hCC, 16'h0000, 16'h0000);
      send_command(OP_MOVE, 8'hCB, 16'h0000, 16'h0000);
      // reads: position and time must not leak into the frame
      send_command(OP_READ, 8'h00, 16'h0000, 16'h0000);
      send_command(OP_READ, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_command(OP_READ, 8'h5A, 16'hA5A5, 16'h5A5A);
      send_command(OP_READ, 8'hBF, 16'h1234, 16'h8765);
      send_command(OP_READ, 8'hC0, 16'hFFFF, 16'h0000);
      // alternate frame lengths back to back
      send_command(OP_MOVE, 8'h80, 16'h8000, 16'h0001);
      send_command(OP_READ, 8'h7F, 16'h0001, 16'h8000);
      send_command(OP_MOVE, 8'h7F, 16'h7FFF, 16'hFFFE);
      send_command(OP_READ, 8'h80, 16'hFFFE, 16'h7FFF);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 50 && i < 90);
         op = ($urandom_range(0, 1) == 1) ? OP_READ : OP_MOVE;
         send_command(op, 8'($urandom_range(0, 255)), pick_field16(), pick_field16());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      // drain: catch any stray words after the last frame
      repeat (24) @(posedge clock);

      $display("Covered %0d move and %0d read commands, %0d frame bytes checked.",
               sb.moves, sb.reads, sb.words_checked);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ servo_command_frame_builder_unit.f @@
+incdir+hw/rtl
hw/rtl/scfb_pkg.sv
hw/rtl/scfb_front.sv
hw/rtl/scfb_queue.sv
hw/rtl/scfb_back.sv
hw/rtl/servo_command_frame_builder_unit.sv
verif/servo_command_frame_builder_unit_tb.sv
